FILE: rtl/core/weighted_event_selector_top_defines.svh
// assertion macros for the weighted event selector
`ifndef WEIGHTED_EVENT_SELECTOR_TOP_DEFINES_SVH
`define WEIGHTED_EVENT_SELECTOR_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WES_ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("wes: same-cycle check failed");

// next-cycle implication, checked outside reset
`define WES_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("wes: next-cycle check failed");

`endif

FILE: rtl/core/wes_pkg.sv
package wes_pkg;

  // table geometry and field widths
  localparam int unsigned TABLE_DEPTH = 1024;
  localparam int unsigned RATE_BITS   = 32;
  localparam int unsigned IDX_W       = $clog2(TABLE_DEPTH);
  localparam int unsigned CNT_W       = $clog2(TABLE_DEPTH + 1);
  localparam int unsigned SUM_W       = 43;
  localparam int unsigned RATE_W      = 32;
  localparam int unsigned OBJ_W       = 16;
  localparam int unsigned KIND_W      = 3;
  localparam int unsigned FRAC_W      = 32;
  localparam int unsigned SEL_W       = 10;
  localparam int unsigned STATUS_W    = 2;
  localparam int unsigned OP_W        = 2;
  localparam int unsigned SUM_HI_W    = SUM_W - FRAC_W;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 32;

  // only the low RATE_BITS of a rate count
  localparam logic [RATE_W-1:0] RATE_MASK =
    (RATE_BITS >= RATE_W) ? {RATE_W{1'b1}} : RATE_W'((64'd1 << RATE_BITS) - 64'd1);
  localparam logic [SUM_W-1:0]  SUM_MAX   = {SUM_W{1'b1}};
  localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(TABLE_DEPTH);

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CASCADE = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_HELIUM  = 1'b1;

  // special entries
  localparam logic [KIND_W-1:0] KIND_HELIUM  = 3'd5;
  localparam logic [KIND_W-1:0] KIND_CASCADE = 3'd6;
  localparam logic [OBJ_W-1:0]  NO_OBJECT    = 16'hFFFF;

  typedef enum logic [OP_W-1:0] {
    OP_CLEAR  = 2'd0,
    OP_APPEND = 2'd1,
    OP_CLOSE  = 2'd2,
    OP_DRAW   = 2'd3
  } op_e;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    SRC_INPUT   = 2'd0,
    SRC_CASCADE = 2'd1,
    SRC_HELIUM  = 2'd2
  } add_src_e;

  // one table entry
  typedef struct packed {
    logic [SUM_W-1:0]  cum;
    logic [OBJ_W-1:0]  obj;
    logic [KIND_W-1:0] kind;
  } entry_t;

  // controller to datapath
  typedef struct packed {
    logic     load;
    logic     clear;
    logic     add;
    add_src_e src;
    logic     mul_lo;
    logic     mul_hi;
    logic     rd_mid;
    logic     cmp;
    logic     rd_final;
    logic     capture;
    logic     out_load;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic cascade_nz;
    logic helium_nz;
    logic count_zero;
    logic search_done;
    logic out_free;
  } st_t;

endpackage

FILE: rtl/core/wes_ram.sv
module wes_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // single port, registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end else begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/core/wes_ctrl.sv
module wes_ctrl (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        in_valid_i,
  input  logic [wes_pkg::OP_W-1:0]    in_operation_i,
  input  wes_pkg::st_t                st_i,
  output wes_pkg::cmd_t               cmd_o,
  output logic                        in_ready_o
);

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_APPEND,
    S_CASCADE,
    S_HELIUM,
    S_MUL_LO,
    S_MUL_HI,
    S_PROBE,
    S_COMPARE,
    S_PICK,
    S_DONE
  } state_e;

  state_e state_q, state_d;

  // next state and command decode
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    cmd_o.src = wes_pkg::SRC_INPUT;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          case (wes_pkg::op_e'(in_operation_i))
            wes_pkg::OP_CLEAR:  state_d = S_CLEAR;
            wes_pkg::OP_APPEND: state_d = S_APPEND;
            wes_pkg::OP_CLOSE:  state_d = S_CASCADE;
            default:            state_d = S_MUL_LO;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.clear = 1'b1;
        state_d     = S_DONE;
      end
      S_APPEND: begin
        cmd_o.add = 1'b1;
        state_d   = S_DONE;
      end
      S_CASCADE: begin
        cmd_o.add = st_i.cascade_nz;
        cmd_o.src = wes_pkg::SRC_CASCADE;
        state_d   = S_HELIUM;
      end
      S_HELIUM: begin
        cmd_o.add = st_i.helium_nz;
        cmd_o.src = wes_pkg::SRC_HELIUM;
        state_d   = S_DONE;
      end
      S_MUL_LO: begin
        cmd_o.mul_lo = 1'b1;
        state_d      = st_i.count_zero ? S_DONE : S_MUL_HI;
      end
      S_MUL_HI: begin
        cmd_o.mul_hi = 1'b1;
        state_d      = S_PROBE;
      end
      S_PROBE: begin
        if (st_i.search_done) begin
          cmd_o.rd_final = 1'b1;
          state_d        = S_PICK;
        end else begin
          cmd_o.rd_mid = 1'b1;
          state_d      = S_COMPARE;
        end
      end
      S_COMPARE: begin
        cmd_o.cmp = 1'b1;
        state_d   = S_PROBE;
      end
      S_PICK: begin
        cmd_o.capture = 1'b1;
        state_d       = S_DONE;
      end
      S_DONE: begin
        if (st_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == S_IDLE);

endmodule

FILE: rtl/core/wes_datapath.sv
module wes_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  wes_pkg::cmd_t                       cmd_i,
  output wes_pkg::st_t                        st_o,
  // input payload
  input  logic [wes_pkg::OP_W-1:0]            in_operation_i,
  input  logic [wes_pkg::RATE_W-1:0]          in_rate_i,
  input  logic [wes_pkg::OBJ_W-1:0]           in_object_index_i,
  input  logic [wes_pkg::KIND_W-1:0]          in_event_kind_i,
  input  logic [wes_pkg::FRAC_W-1:0]          in_random_fraction_i,
  // configuration writes
  input  logic                                cfg_we_i,
  input  logic [wes_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [wes_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  // result
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [wes_pkg::SUM_W-1:0]           out_total_rate_o,
  output logic [wes_pkg::SEL_W-1:0]           out_selected_entry_o,
  output logic [wes_pkg::OBJ_W-1:0]           out_chosen_object_o,
  output logic [wes_pkg::KIND_W-1:0]          out_chosen_kind_o,
  output logic [wes_pkg::STATUS_W-1:0]        out_status_o
);

  // control state
  logic [wes_pkg::CNT_W-1:0]      count_q;
  logic [wes_pkg::SUM_W-1:0]      sum_q;
  logic [wes_pkg::RATE_W-1:0]     cascade_q;
  logic [wes_pkg::RATE_W-1:0]     helium_q;
  logic                           out_valid_q;
  logic                           dropped_q;

  // latched transaction and search registers
  wes_pkg::op_e                   op_q;
  logic [wes_pkg::RATE_W-1:0]     rate_q;
  logic [wes_pkg::OBJ_W-1:0]      obj_q;
  logic [wes_pkg::KIND_W-1:0]     kind_q;
  logic [wes_pkg::FRAC_W-1:0]     frac_q;
  logic [wes_pkg::FRAC_W-1:0]     prod_hi_q;
  logic [wes_pkg::SUM_W-1:0]      target_q;
  logic [wes_pkg::IDX_W-1:0]      lo_q;
  logic [wes_pkg::IDX_W-1:0]      hi_q;
  logic [wes_pkg::IDX_W-1:0]      mid_q;
  logic [wes_pkg::IDX_W-1:0]      pick_sel_q;
  logic [wes_pkg::OBJ_W-1:0]      pick_obj_q;
  logic [wes_pkg::KIND_W-1:0]     pick_kind_q;

  // result registers
  logic [wes_pkg::SUM_W-1:0]      res_total_q;
  logic [wes_pkg::IDX_W-1:0]      res_sel_q;
  logic [wes_pkg::OBJ_W-1:0]      res_obj_q;
  logic [wes_pkg::KIND_W-1:0]     res_kind_q;
  wes_pkg::status_e               res_status_q;

  logic                           full;
  logic                           do_write;
  logic [wes_pkg::RATE_W-1:0]     add_rate;
  logic [wes_pkg::OBJ_W-1:0]      add_obj;
  logic [wes_pkg::KIND_W-1:0]     add_kind;
  logic [wes_pkg::SUM_W:0]        sum_ext;
  logic [wes_pkg::SUM_W-1:0]      new_sum;
  logic [2*wes_pkg::FRAC_W-1:0]   prod_lo;
  logic [wes_pkg::SUM_W-1:0]      prod_hi_part;
  logic [wes_pkg::IDX_W:0]        mid_sum;
  logic [wes_pkg::IDX_W-1:0]      mid;
  logic [wes_pkg::IDX_W-1:0]      ram_addr;
  wes_pkg::entry_t                wr_entry;
  wes_pkg::entry_t                rd_entry;
  wes_pkg::status_e               status_d;

  assign full     = (count_q == wes_pkg::CNT_FULL);
  assign do_write = cmd_i.add && !full;

  // entry source select
  always_comb begin
    case (cmd_i.src)
      wes_pkg::SRC_CASCADE: begin
        add_rate = cascade_q;
        add_obj  = wes_pkg::NO_OBJECT;
        add_kind = wes_pkg::KIND_CASCADE;
      end
      wes_pkg::SRC_HELIUM: begin
        add_rate = helium_q;
        add_obj  = wes_pkg::OBJ_W'(count_q);
        add_kind = wes_pkg::KIND_HELIUM;
      end
      default: begin
        add_rate = rate_q;
        add_obj  = obj_q;
        add_kind = kind_q;
      end
    endcase
  end

  // saturating running sum
  assign sum_ext = {1'b0, sum_q} + (wes_pkg::SUM_W + 1)'(add_rate & wes_pkg::RATE_MASK);
  assign new_sum = sum_ext[wes_pkg::SUM_W] ? wes_pkg::SUM_MAX : sum_ext[wes_pkg::SUM_W-1:0];

  // scaled target, low half first, then high half plus carry-in
  assign prod_lo      = (2*wes_pkg::FRAC_W)'(frac_q) *
                        (2*wes_pkg::FRAC_W)'(sum_q[wes_pkg::FRAC_W-1:0]);
  assign prod_hi_part = wes_pkg::SUM_W'(frac_q) *
                        wes_pkg::SUM_W'(sum_q[wes_pkg::SUM_W-1:wes_pkg::FRAC_W]);

  // search midpoint
  assign mid_sum = {1'b0, lo_q} + {1'b0, hi_q};
  assign mid     = mid_sum[wes_pkg::IDX_W:1];

  // table port address
  always_comb begin
    if (do_write) begin
      ram_addr = count_q[wes_pkg::IDX_W-1:0];
    end else if (cmd_i.rd_mid) begin
      ram_addr = mid;
    end else begin
      ram_addr = lo_q;
    end
  end

  assign wr_entry.cum  = new_sum;
  assign wr_entry.obj  = add_obj;
  assign wr_entry.kind = add_kind;

  wes_ram #(
    .WIDTH ($bits(wes_pkg::entry_t)),
    .DEPTH (wes_pkg::TABLE_DEPTH)
  ) u_table (
    .clk_i   (clk_i),
    .we_i    (do_write),
    .addr_i  (ram_addr),
    .wdata_i (wr_entry),
    .rdata_o (rd_entry)
  );

  // status of the finished transaction
  always_comb begin
    case (op_q)
      wes_pkg::OP_APPEND: status_d = dropped_q ? wes_pkg::STATUS_FULL : wes_pkg::STATUS_OK;
      wes_pkg::OP_CLOSE: begin
        if (dropped_q) begin
          status_d = wes_pkg::STATUS_FULL;
        end else if (count_q == '0) begin
          status_d = wes_pkg::STATUS_EMPTY;
        end else begin
          status_d = wes_pkg::STATUS_OK;
        end
      end
      wes_pkg::OP_DRAW:
        status_d = (count_q == '0) ? wes_pkg::STATUS_EMPTY : wes_pkg::STATUS_OK;
      default: status_d = wes_pkg::STATUS_OK;
    endcase
  end

  // table state, configuration and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      sum_q       <= '0;
      cascade_q   <= '0;
      helium_q    <= '0;
      out_valid_q <= 1'b0;
      dropped_q   <= 1'b0;
    end else begin
      if (cfg_we_i && cfg_index_i == wes_pkg::CFG_CASCADE) begin
        cascade_q <= cfg_data_i;
      end
      if (cfg_we_i && cfg_index_i == wes_pkg::CFG_HELIUM) begin
        helium_q <= cfg_data_i;
      end
      if (cmd_i.load) begin
        dropped_q <= 1'b0;
      end else if (cmd_i.add && full) begin
        dropped_q <= 1'b1;
      end
      if (cmd_i.clear) begin
        count_q <= '0;
        sum_q   <= '0;
      end else if (do_write) begin
        count_q <= count_q + 1'b1;
        sum_q   <= new_sum;
      end
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // transaction payload, search and result registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q        <= wes_pkg::op_e'(in_operation_i);
      rate_q      <= in_rate_i;
      obj_q       <= in_object_index_i;
      kind_q      <= in_event_kind_i;
      frac_q      <= in_random_fraction_i;
      pick_sel_q  <= '0;
      pick_obj_q  <= '0;
      pick_kind_q <= '0;
    end
    if (cmd_i.mul_lo) begin
      prod_hi_q <= prod_lo[2*wes_pkg::FRAC_W-1:wes_pkg::FRAC_W];
    end
    if (cmd_i.mul_hi) begin
      target_q <= prod_hi_part + wes_pkg::SUM_W'(prod_hi_q);
      lo_q     <= '0;
      hi_q     <= wes_pkg::IDX_W'(count_q - 1'b1);
    end
    if (cmd_i.rd_mid) begin
      mid_q <= mid;
    end
    if (cmd_i.cmp) begin
      if (rd_entry.cum >= target_q) begin
        hi_q <= mid_q;
      end else begin
        lo_q <= mid_q + 1'b1;
      end
    end
    if (cmd_i.capture) begin
      pick_sel_q  <= lo_q;
      pick_obj_q  <= rd_entry.obj;
      pick_kind_q <= rd_entry.kind;
    end
    if (cmd_i.out_load) begin
      res_total_q  <= sum_q;
      res_sel_q    <= pick_sel_q;
      res_obj_q    <= pick_obj_q;
      res_kind_q   <= pick_kind_q;
      res_status_q <= status_d;
    end
  end

  assign st_o.cascade_nz  = (cascade_q != '0);
  assign st_o.helium_nz   = (helium_q != '0);
  assign st_o.count_zero  = (count_q == '0);
  assign st_o.search_done = (lo_q == hi_q);
  assign st_o.out_free    = !out_valid_q || out_ready_i;

  assign out_valid_o          = out_valid_q;
  assign out_total_rate_o     = res_total_q;
  assign out_selected_entry_o = wes_pkg::SEL_W'(res_sel_q);
  assign out_chosen_object_o  = res_obj_q;
  assign out_chosen_kind_o    = res_kind_q;
  assign out_status_o         = res_status_q;

endmodule

FILE: rtl/core/weighted_event_selector_top.sv
// Rate table and event selector for a kinetic Monte Carlo engine. Clear empties
// the table; append stores one event with the running cumulative rate (saturating
// at 2^43-1); close adds the cascade and helium-insert entries for nonzero rates and
// reports the total; draw scales the 32-bit fraction by the total and binary-searches
// the first entry whose cumulative rate is at least that value. One transaction is
// in work at a time, and the next is taken while the previous result waits in the
// output register. Each search step of a draw is one read of the single-port table
// RAM with registered read data followed by a compare, so draw time is set by that
// read-compare loop. Configuration is always ready and must be written while idle;
// the block itself does not enforce this.

`include "weighted_event_selector_top_defines.svh"

module weighted_event_selector_top (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  // input transactions
  input  logic                             in_valid_i,
  output logic                             in_ready_o,
  input  logic [wes_pkg::OP_W-1:0]         in_operation_i,
  input  logic [wes_pkg::RATE_W-1:0]       in_rate_i,
  input  logic [wes_pkg::OBJ_W-1:0]        in_object_index_i,
  input  logic [wes_pkg::KIND_W-1:0]       in_event_kind_i,
  input  logic [wes_pkg::FRAC_W-1:0]       in_random_fraction_i,
  // configuration writes
  input  logic                             cfg_valid_i,
  output logic                             cfg_ready_o,
  input  logic [wes_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [wes_pkg::CFG_DATA_W-1:0]   cfg_data_i,
  // result transactions
  output logic                             out_valid_o,
  input  logic                             out_ready_i,
  output logic [wes_pkg::SUM_W-1:0]        out_total_rate_o,
  output logic [wes_pkg::SEL_W-1:0]        out_selected_entry_o,
  output logic [wes_pkg::OBJ_W-1:0]        out_chosen_object_o,
  output logic [wes_pkg::KIND_W-1:0]       out_chosen_kind_o,
  output logic [wes_pkg::STATUS_W-1:0]     out_status_o
);

  wes_pkg::cmd_t cmd;
  wes_pkg::st_t  st;

  assign cfg_ready_o = 1'b1;

  // sequencer
  wes_ctrl u_ctrl (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_operation_i (in_operation_i),
    .st_i           (st),
    .cmd_o          (cmd),
    .in_ready_o     (in_ready_o)
  );

  // table, arithmetic and result registers
  wes_datapath u_dp (
    .clk_i                (clk_i),
    .rst_ni               (rst_ni),
    .cmd_i                (cmd),
    .st_o                 (st),
    .in_operation_i       (in_operation_i),
    .in_rate_i            (in_rate_i),
    .in_object_index_i    (in_object_index_i),
    .in_event_kind_i      (in_event_kind_i),
    .in_random_fraction_i (in_random_fraction_i),
    .cfg_we_i             (cfg_valid_i),
    .cfg_index_i          (cfg_index_i),
    .cfg_data_i           (cfg_data_i),
    .out_ready_i          (out_ready_i),
    .out_valid_o          (out_valid_o),
    .out_total_rate_o     (out_total_rate_o),
    .out_selected_entry_o (out_selected_entry_o),
    .out_chosen_object_o  (out_chosen_object_o),
    .out_chosen_kind_o    (out_chosen_kind_o),
    .out_status_o         (out_status_o)
  );

  // one transaction in work at a time
  `WES_ASSERT_NEXT(a_single_txn, clk_i, rst_ni, in_valid_i && in_ready_o, !in_ready_o)
  // a collapsed search range is never probed again
  `WES_ASSERT_SAME(a_probe_open, clk_i, rst_ni, cmd.rd_mid, !st.search_done)
  // a waiting result is never overwritten
  `WES_ASSERT_SAME(a_out_free, clk_i, rst_ni, cmd.out_load, st.out_free)

endmodule
